// ----- sv/tptc_pkg.sv -----
// Package with shared constants and types of the tunnel peer timer controller.
`timescale 1ns / 1ps
package tptc_pkg;
	localparam int PEERS_DEF = 256;
	localparam int TIMER_BITS_DEF = 20;
	localparam int NTIMERS = 5;

	localparam logic [3:0] FN_TICK = 4'd0;
	localparam logic [3:0] FN_TRAVERSAL = 4'd1;
	localparam logic [3:0] FN_AUTH_SENT = 4'd2;
	localparam logic [3:0] FN_HS_INIT = 4'd3;
	localparam logic [3:0] FN_SESSION = 4'd4;
	localparam logic [3:0] FN_DATA_SENT = 4'd5;
	localparam logic [3:0] FN_DATA_RECV = 4'd6;
	localparam logic [3:0] FN_HS_DONE = 4'd7;
	localparam logic [3:0] FN_AUTH_RECV = 4'd8;
	localparam logic [3:0] FN_STOP_ALL = 4'd9;
	localparam logic [3:0] FN_INIT = 4'd10;

	localparam logic [1:0] ACT_HANDSHAKE = 2'd0;
	localparam logic [1:0] ACT_KEEPALIVE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] REG_TPS = 3'd0;
	localparam logic [2:0] REG_REKEY = 3'd1;
	localparam logic [2:0] REG_KEEPALIVE = 3'd2;
	localparam logic [2:0] REG_ZERO = 3'd3;
	localparam logic [2:0] REG_MAXATT = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic       is_retry;
	} act_t;
endpackage

// ----- sv/tunnel_peer_timer_controller_core.sv -----
// Top level of the tunnel peer timer controller.
`timescale 1ns / 1ps
// Flow: the peer row is read at the transfer edge and written back at the next edge,
// where the event's actions enter the output queue and are presented from there in order.
// Input: a new event is not taken while the previous one awaits its writeback, and
// the input stalls while queued actions could overflow.
// Reset: arst_n restores the register defaults and starts a clearing pass over all PEERS
// rows (256 by default) of the peer memory, during which the input stalls.
module tunnel_peer_timer_controller_core #(
	parameter int PEERS = tptc_pkg::PEERS_DEF,
	parameter int TIMER_BITS = tptc_pkg::TIMER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [7:0]  peer_index,
	input  logic [15:0] persist_interval,
	input  logic [9:0]  jitter,
	input  logic        peer_dead,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_peer,
	output logic [1:0]  action,
	output logic        is_retry,
	output logic        last
);
	import tptc_pkg::*;

	localparam int PW = (PEERS > 1) ? $clog2(PEERS) : 1;
	localparam int TW = NTIMERS * TIMER_BITS;
	localparam int ROW_W = TW + NTIMERS + 8 + 1;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	localparam int QD = 16;
	localparam int QW = 4;

	// Configuration registers.
	logic [9:0]  tps_q;
	logic [19:0] rekey_q, keep_q, zero_q;
	logic [7:0]  maxatt_q;
	wire cfg_wr = psel && penable && pwrite;
	wire [2:0] cfg_idx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= 10'd100;
			rekey_q <= 20'd500;
			keep_q <= 20'd1000;
			zero_q <= 20'd54000;
			maxatt_q <= 8'd18;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TPS:       tps_q <= pwdata[9:0];
				REG_REKEY:     rekey_q <= pwdata[19:0];
				REG_KEEPALIVE: keep_q <= pwdata[19:0];
				REG_ZERO:      zero_q <= pwdata[19:0];
				REG_MAXATT:    maxatt_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TPS:       prdata = {22'd0, tps_q};
			REG_REKEY:     prdata = {12'd0, rekey_q};
			REG_KEEPALIVE: prdata = {12'd0, keep_q};
			REG_ZERO:      prdata = {12'd0, zero_q};
			REG_MAXATT:    prdata = {24'd0, maxatt_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Clamp a wide interval into the timer range and raise zero to one.
	function automatic logic [TIMER_BITS-1:0] clamp_iv(input logic [35:0] v);
		logic [TIMER_BITS-1:0] r;
		if (v > 36'(TMAX)) r = TMAX;
		else r = v[TIMER_BITS-1:0];
		if (r == '0) r = {{(TIMER_BITS-1){1'b0}}, 1'b1};
		return r;
	endfunction

	// Clearing pass: after reset every peer row is written with zeros, one per cycle.
	logic          clr_busy_q;
	logic [PW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == PW'(PEERS - 1)) clr_busy_q <= 1'b0;
		end
	end

	// Stage 0: a transfer is taken, the peer record read is issued, and the
	// intervals are prepared. The persistent product gets its own register.
	logic        busy_s1;
	logic        v_s1;
	logic [3:0]  func_s1;
	logic [7:0]  peer_s1;
	logic        pz_s1, dead_s1;
	logic [TIMER_BITS-1:0] iv_persist_s1, iv_retx_s1, iv_newhs_s1;
	logic [TIMER_BITS-1:0] iv_keep_s1, iv_zero_s1;
	logic [QW:0] q_cnt_q;
	logic [QW:0] q_pend;

	// Room check: at most five actions per event plus one event in flight.
	assign in_stall = clr_busy_q || busy_s1 || (q_cnt_q > 5'(QD - 10));
	wire in_take = in_valid && !in_stall;
	wire in_range = (32'(peer_index) < PEERS);
	wire [PW-1:0] rd_addr = PW'(peer_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			busy_s1 <= in_take;
			v_s1 <= in_take && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= func;
			peer_s1 <= peer_index;
			pz_s1 <= (persist_interval == 16'd0);
			dead_s1 <= peer_dead;
			iv_persist_s1 <= clamp_iv(36'(persist_interval) * 36'(tps_q));
			iv_retx_s1 <= clamp_iv(36'(rekey_q) + 36'(jitter));
			iv_newhs_s1 <= clamp_iv(36'(keep_q) + 36'(rekey_q) + 36'(jitter));
			iv_keep_s1 <= clamp_iv(36'(keep_q));
			iv_zero_s1 <= clamp_iv(36'(zero_q));
		end
	end

	// Peer memory: one row per peer holds the five counts, the armed bits, the
	// attempt count and the keepalive flag, in that order from the top.
	logic [ROW_W-1:0] peer_mem [PEERS];
	logic [ROW_W-1:0] rd_row;
	logic [TW-1:0] left_rd;
	logic wr_en;
	logic [TW-1:0] wr_left;
	wire [PW-1:0] pa = PW'(peer_s1);

	// Stage 1: modify. Because the input stalls while an event is in flight, the
	// read of the next event always sees the writeback of this one.
	logic [NTIMERS-1:0] arm_cur, arm_new;
	logic [7:0] att_cur, att_new;
	logic ak_cur, ak_new;
	logic [TIMER_BITS-1:0] lf [NTIMERS];
	logic [NTIMERS-1:0] hit;
	act_t acts [NTIMERS];
	logic [NTIMERS-1:0] emit;

	always_ff @(posedge clk) begin
		if (clr_busy_q) peer_mem[clr_addr_q] <= '0;
		else if (wr_en) peer_mem[pa] <= {wr_left, arm_new, att_new, ak_new};
		if (in_take) rd_row <= peer_mem[rd_addr];
	end

	assign left_rd = rd_row[ROW_W-1 -: TW];

	always_comb begin
		arm_cur = rd_row[NTIMERS+8:9];
		att_cur = rd_row[8:1];
		ak_cur = rd_row[0];
		arm_new = arm_cur;
		att_new = att_cur;
		ak_new = ak_cur;
		emit = '0;
		hit = '0;
		for (int t = 0; t < NTIMERS; t++) begin
			lf[t] = left_rd[t*TIMER_BITS +: TIMER_BITS];
			acts[t] = '{action: ACT_HANDSHAKE, is_retry: 1'b0};
		end
		case (func_s1)
			FN_TICK: begin
				for (int t = 0; t < NTIMERS; t++) begin
					if (arm_cur[t]) begin
						if (lf[t] != '0) lf[t] = lf[t] - 1'b1;
						hit[t] = (lf[t] == '0);
					end
				end
				// Retransmit handshake.
				if (hit[0]) begin
					arm_new[0] = 1'b0;
					if (att_cur > maxatt_q) begin
						arm_new[2] = 1'b0;
						if (!arm_new[4]) begin
							arm_new[4] = 1'b1;
							lf[4] = iv_zero_s1;
						end
					end else begin
						if (att_cur != 8'hFF) att_new = att_cur + 8'd1;
						emit[0] = 1'b1;
						acts[0] = '{action: ACT_HANDSHAKE, is_retry: 1'b1};
					end
				end
				// Persistent keepalive.
				if (hit[1]) begin
					arm_new[1] = 1'b0;
					emit[1] = !pz_s1;
					acts[1] = '{action: ACT_KEEPALIVE, is_retry: 1'b0};
				end
				// Passive keepalive, skipped when stopped earlier in this tick.
				if (hit[2] && arm_new[2]) begin
					arm_new[2] = 1'b0;
					emit[2] = 1'b1;
					acts[2] = '{action: ACT_KEEPALIVE, is_retry: 1'b0};
					if (ak_cur) begin
						ak_new = 1'b0;
						arm_new[2] = 1'b1;
						lf[2] = iv_keep_s1;
					end
				end
				if (hit[3]) begin
					arm_new[3] = 1'b0;
					emit[3] = 1'b1;
					acts[3] = '{action: ACT_HANDSHAKE, is_retry: 1'b0};
				end
				// Key zeroing, skipped when rearmed earlier in this tick.
				if (hit[4] && (lf[4] == '0)) begin
					arm_new[4] = 1'b0;
					emit[4] = !dead_s1;
					acts[4] = '{action: ACT_CLEAR, is_retry: 1'b0};
				end
			end
			FN_TRAVERSAL: if (!pz_s1) begin
				arm_new[1] = 1'b1;
				lf[1] = iv_persist_s1;
			end
			FN_AUTH_SENT: arm_new[2] = 1'b0;
			FN_HS_INIT: begin
				arm_new[0] = 1'b1;
				lf[0] = iv_retx_s1;
			end
			FN_SESSION: begin
				arm_new[4] = 1'b1;
				lf[4] = iv_zero_s1;
			end
			FN_DATA_SENT: if (!arm_cur[3]) begin
				arm_new[3] = 1'b1;
				lf[3] = iv_newhs_s1;
			end
			FN_DATA_RECV: begin
				if (!arm_cur[2]) begin
					arm_new[2] = 1'b1;
					lf[2] = iv_keep_s1;
				end else ak_new = 1'b1;
			end
			FN_HS_DONE: begin
				arm_new[0] = 1'b0;
				att_new = 8'd0;
			end
			FN_AUTH_RECV: arm_new[3] = 1'b0;
			FN_STOP_ALL, FN_INIT: arm_new = '0;
			default: ;
		endcase
		for (int t = 0; t < NTIMERS; t++) wr_left[t*TIMER_BITS +: TIMER_BITS] = lf[t];
	end

	assign wr_en = v_s1;

	// Output queue: actions of one event enter together, the final one marked.
	logic [11:0] q_mem [QD];
	logic [QW-1:0] q_wp_q, q_rp_q;
	logic [2:0] last_idx;
	logic [2:0] n_emit;
	always_comb begin
		last_idx = 3'd0;
		n_emit = 3'd0;
		for (int t = 0; t < NTIMERS; t++) begin
			if (emit[t] && v_s1) begin
				last_idx = 3'(t);
				n_emit = n_emit + 3'd1;
			end
		end
	end

	wire q_pop = out_valid && !out_stall;
	assign q_pend = q_cnt_q + 5'(n_emit) - 5'(q_pop);

	always_ff @(posedge clk) begin
		logic [QW-1:0] w;
		w = q_wp_q;
		for (int t = 0; t < NTIMERS; t++) begin
			if (emit[t] && v_s1) begin
				q_mem[w] <= {peer_s1, acts[t].action, acts[t].is_retry,
					(3'(t) == last_idx)};
				w = w + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q <= '0;
			q_rp_q <= '0;
			q_cnt_q <= '0;
		end else begin
			q_wp_q <= q_wp_q + QW'(n_emit);
			if (q_pop) q_rp_q <= q_rp_q + 1'b1;
			q_cnt_q <= q_pend;
		end
	end

	assign out_valid = (q_cnt_q != '0);
	assign {out_peer, action, is_retry, last} = q_mem[q_rp_q];
endmodule

// ----- sv/tptc_checker.sv -----
// Port-level checker for the tunnel peer timer controller, with its bind.
`timescale 1ns / 1ps
module tptc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] action,
	input logic       is_retry,
	input logic       pready
);
	import tptc_pkg::*;

	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (action == ACT_HANDSHAKE || action == ACT_KEEPALIVE ||
			action == ACT_CLEAR))
		else $error("undefined action code");
	a_retry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_retry) |-> (action == ACT_HANDSHAKE))
		else $error("retry flag on a non-handshake action");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("two transfers in adjacent cycles");
	a_ready: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind tunnel_peer_timer_controller_core tptc_checker u_tptc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .action(action),
	.is_retry(is_retry), .pready(pready)
);
